>>> rtl/core/kcte_pkg.sv
// Shared types, constants and key tables for the keyed config text extractor.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package kcte_pkg;

  localparam int CMD_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 4;
  localparam int ACC_W       = 32;
  localparam int POS_W       = 4;
  localparam int NUM_KEYS    = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DATA  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EOF   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  localparam logic [1:0] KEY_CONF = 2'd0;
  localparam logic [1:0] KEY_MOD  = 2'd1;
  localparam logic [1:0] KEY_NAME = 2'd2;
  localparam logic [1:0] KEY_DEF  = 2'd3;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
  localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
  localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_M     = 8'h4D;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_BEGIN = 3'd2,
    OP_DATA  = 3'd3,
    OP_EOF   = 3'd4,
    OP_READ  = 3'd5
  } op_kind_t;

  typedef enum logic [5:0] {
    PH_PRE  = 6'b000001,
    PH_IDLE = 6'b000010,
    PH_CONF = 6'b000100,
    PH_MOD  = 6'b001000,
    PH_NAME = 6'b010000,
    PH_DEF  = 6'b100000
  } phase_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [BYTE_W-1:0] byte_val;
    logic [IDX_W-1:0]  idx;
    logic              idx_ok;
  } q_item_t;

  typedef struct packed {
    logic clear;
    logic wr_en;
    logic close;
    logic rd_en;
  } ns_ctrl_t;

  // Key character at a match position; 0 marks the terminator.
  function automatic logic [BYTE_W-1:0] key_char(input logic [1:0] key,
                                                 input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] ch;
    ch = CH_NUL;
    case (key)
      KEY_CONF: begin
        case (pos)
          4'd0: ch = "C";
          4'd1: ch = "O";
          4'd2: ch = "N";
          4'd3: ch = "F";
          4'd4: ch = "=";
          default: ch = CH_NUL;
        endcase
      end
      KEY_MOD: begin
        case (pos)
          4'd0: ch = "M";
          4'd1: ch = "O";
          4'd2: ch = "D";
          default: ch = CH_NUL;
        endcase
      end
      KEY_NAME: begin
        case (pos)
          4'd0: ch = "N";
          4'd1: ch = "A";
          4'd2: ch = "M";
          4'd3: ch = "E";
          default: ch = CH_NUL;
        endcase
      end
      KEY_DEF: begin
        case (pos)
          4'd0: ch = "D";
          4'd1: ch = "E";
          4'd2: ch = "F";
          4'd3: ch = "A";
          4'd4: ch = "U";
          4'd5: ch = "L";
          4'd6: ch = "T";
          4'd7: ch = "=";
          4'd8: ch = "0";
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic phase_t key_phase(input logic [1:0] key);
    phase_t ph;
    case (key)
      KEY_CONF: ph = PH_CONF;
      KEY_MOD:  ph = PH_MOD;
      KEY_NAME: ph = PH_NAME;
      KEY_DEF:  ph = PH_DEF;
      default:  ph = PH_IDLE;
    endcase
    return ph;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/kcte_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on kcte_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface kcte_in_if;
  logic                          valid;
  logic                          ready;
  logic [kcte_pkg::CMD_W-1:0]    command;
  logic [kcte_pkg::BYTE_W-1:0]   byte_value;
  logic [kcte_pkg::IDX_W-1:0]    name_index;

  modport source (output valid, command, byte_value, name_index, input ready);
  modport sink   (input valid, command, byte_value, name_index, output ready);
endinterface

interface kcte_out_if;
  logic                          valid;
  logic                          ready;
  logic [kcte_pkg::BYTE_W-1:0]   char_out;
  logic                          char_valid;
  logic                          at_end;
  logic                          last;
  logic [kcte_pkg::ACC_W-1:0]    mod_value;
  logic [kcte_pkg::ACC_W-1:0]    default_value;

  modport source (output valid, char_out, char_valid, at_end, last, mod_value,
                  default_value, input ready);
  modport sink   (input valid, char_out, char_valid, at_end, last, mod_value,
                  default_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/kcte_front.sv
// Front end: accepts input transfers, classifies commands and queues them.
// Depends on kcte_pkg and kcte_in_if.
`timescale 1ns / 1ps
`default_nettype none

module kcte_front #(
  parameter int NAME_CHARS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  kcte_in_if.sink                 in_ch,
  output kcte_pkg::q_item_t       q_head,
  output logic                    q_valid,
  input  wire logic               q_pop
);

  localparam int STORE_LEN = NAME_CHARS + 4;
  localparam int QPW       = kcte_pkg::QPTR_W;
  localparam int QCW       = kcte_pkg::QCNT_W;

  kcte_pkg::q_item_t item_c;
  kcte_pkg::q_item_t buf_r [kcte_pkg::QUEUE_DEPTH];
  logic [QPW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    cnt_r, cnt_nxt;
  logic              push;

  always_comb begin
    item_c.byte_val = in_ch.byte_value;
    item_c.idx      = in_ch.name_index;
    item_c.idx_ok   = ({28'd0, in_ch.name_index} < 32'(STORE_LEN));
    case (in_ch.command)
      kcte_pkg::CMD_CLEAR: item_c.kind = kcte_pkg::OP_CLEAR;
      kcte_pkg::CMD_BEGIN: item_c.kind = kcte_pkg::OP_BEGIN;
      kcte_pkg::CMD_DATA:  item_c.kind = kcte_pkg::OP_DATA;
      kcte_pkg::CMD_EOF:   item_c.kind = kcte_pkg::OP_EOF;
      kcte_pkg::CMD_READ:  item_c.kind = kcte_pkg::OP_READ;
      default:             item_c.kind = kcte_pkg::OP_NONE;
    endcase
  end

  assign in_ch.ready = (cnt_r != QCW'(kcte_pkg::QUEUE_DEPTH));
  // unused command codes are dropped here and never reach the back end
  assign push       = in_ch.valid && in_ch.ready && (item_c.kind != kcte_pkg::OP_NONE);

  assign wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
  assign cnt_nxt    = cnt_r + QCW'(push) - QCW'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= item_c;
    end
  end

  assign q_head  = buf_r[rd_ptr_r];
  assign q_valid = (cnt_r != '0);

endmodule

`default_nettype wire

>>> rtl/core/kcte_name_store.sv
// Name store: byte memory with per-entry written/padded flags and ROM tail.
// Depends on kcte_pkg; driven by kcte_back.
`timescale 1ns / 1ps
`default_nettype none

module kcte_name_store #(
  parameter int NAME_CHARS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire kcte_pkg::ns_ctrl_t            ctrl,
  input  wire logic [kcte_pkg::BYTE_W-1:0]   wr_byte,
  input  wire logic [$clog2(NAME_CHARS+2)-1:0] count,
  input  wire logic [kcte_pkg::IDX_W-1:0]    idx,
  output logic [kcte_pkg::BYTE_W-1:0]        rd_char
);

  localparam int NCW = $clog2(NAME_CHARS + 2);
  localparam int MAW = $clog2(NAME_CHARS + 1);
  localparam int CW  = ($clog2(NAME_CHARS + 4) > kcte_pkg::IDX_W) ?
                       $clog2(NAME_CHARS + 4) : kcte_pkg::IDX_W;
  localparam int BW  = kcte_pkg::BYTE_W;

  logic [BW-1:0]         mem [NAME_CHARS+1];
  logic [NAME_CHARS:0]   wr_r, wr_nxt;
  logic [NAME_CHARS:0]   sp_r, sp_nxt;
  logic                  rom_r, rom_nxt;
  logic [BW-1:0]         rd_byte_r;
  logic [BW-1:0]         rd_fixed_r;
  logic                  rd_use_mem_r;

  logic [CW-1:0]  idx_w;
  logic           in_mem;
  logic           sel_wr, sel_sp;
  logic [BW-1:0]  fixed_c;
  logic           use_mem_c;
  logic [MAW-1:0] wa, ra;

  assign idx_w  = CW'(idx);
  assign in_mem = (idx_w <= CW'(NAME_CHARS));
  assign wa     = count[MAW-1:0];
  assign ra     = idx_w[MAW-1:0];

  // flag updates: a write marks its entry as a real byte, a close pads the rest
  always_comb begin
    wr_nxt  = wr_r;
    sp_nxt  = sp_r;
    rom_nxt = rom_r;
    if (ctrl.clear) begin
      wr_nxt  = '0;
      sp_nxt  = '0;
      rom_nxt = 1'b0;
    end else if (ctrl.wr_en) begin
      wr_nxt[wa] = 1'b1;
      sp_nxt[wa] = 1'b0;
    end else if (ctrl.close) begin
      for (int i = 0; i < NAME_CHARS; i++) begin
        if (NCW'(i) >= count) begin
          sp_nxt[i] = 1'b1;
        end
      end
      sp_nxt[NAME_CHARS] = 1'b1;
      rom_nxt            = 1'b1;
    end
  end

  always_comb begin
    sel_wr = 1'b0;
    sel_sp = 1'b0;
    for (int i = 0; i <= NAME_CHARS; i++) begin
      if (idx_w == CW'(i)) begin
        sel_wr = wr_r[i];
        sel_sp = sp_r[i];
      end
    end
    fixed_c = kcte_pkg::CH_NUL;
    if (in_mem) begin
      if (sel_sp) begin
        fixed_c = (idx_w == CW'(NAME_CHARS)) ? kcte_pkg::CH_R : kcte_pkg::CH_SPACE;
      end
    end else if (idx_w == CW'(NAME_CHARS + 1)) begin
      fixed_c = rom_r ? kcte_pkg::CH_O : kcte_pkg::CH_NUL;
    end else if (idx_w == CW'(NAME_CHARS + 2)) begin
      fixed_c = rom_r ? kcte_pkg::CH_M : kcte_pkg::CH_NUL;
    end
    use_mem_c = in_mem && !sel_sp && sel_wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      sp_r  <= '0;
      rom_r <= 1'b0;
    end else begin
      wr_r  <= wr_nxt;
      sp_r  <= sp_nxt;
      rom_r <= rom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wa] <= wr_byte;
    end
    if (ctrl.rd_en && in_mem) begin
      rd_byte_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_fixed_r   <= fixed_c;
      rd_use_mem_r <= use_mem_c;
    end
  end

  assign rd_char = rd_use_mem_r ? rd_byte_r : rd_fixed_r;

endmodule

`default_nettype wire

>>> rtl/core/kcte_back.sv
// Back end: key matchers, field parsers, accumulators and the result register.
// Depends on kcte_pkg, kcte_out_if; drives kcte_name_store.
`timescale 1ns / 1ps
`default_nettype none

module kcte_back #(
  parameter int NAME_CHARS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire kcte_pkg::q_item_t               q_head,
  input  wire logic                            q_valid,
  output logic                                 q_pop,
  output kcte_pkg::ns_ctrl_t                   ns_ctrl,
  output logic [kcte_pkg::BYTE_W-1:0]          ns_wr_byte,
  output logic [$clog2(NAME_CHARS+2)-1:0]      ns_count,
  output logic [kcte_pkg::IDX_W-1:0]           ns_idx,
  input  wire logic [kcte_pkg::BYTE_W-1:0]     ns_rd_char,
  kcte_out_if.source                           out_ch
);

  localparam int NCW = $clog2(NAME_CHARS + 2);
  localparam int BW  = kcte_pkg::BYTE_W;
  localparam int AW  = kcte_pkg::ACC_W;
  localparam int PW  = kcte_pkg::POS_W;
  localparam int NK  = kcte_pkg::NUM_KEYS;

  kcte_pkg::phase_t phase_r, phase_nxt, eff_ph;
  logic [PW-1:0]    mpos_r [NK];
  logic [PW-1:0]    mpos_nxt [NK];
  logic [NCW-1:0]   ncnt_r, ncnt_nxt;
  logic [AW-1:0]    mod_r, mod_nxt;
  logic [AW-1:0]    def_r, def_nxt;

  // result register: holds one or two pending results of one item
  logic [1:0]       ocnt_r;
  logic [BW-1:0]    ochar_r;
  logic             ovalid_r;
  logic             oend_r;
  logic             ofrom_r;
  logic [AW-1:0]    omod_r;
  logic [AW-1:0]    odef_r;

  kcte_pkg::ns_ctrl_t ctrl_c;
  logic             has_res;
  logic [1:0]       res_n;
  logic [BW-1:0]    res_char;
  logic             res_valid, res_end, res_from;

  logic [BW-1:0]    c;
  logic             eol, is_dig, is_hex;
  logic             r_free, fire, out_xfer;

  assign c      = q_head.byte_val;
  assign eol    = (c == kcte_pkg::CH_LF) || (c == kcte_pkg::CH_CR);
  assign is_dig = (c >= kcte_pkg::CH_ZERO) && (c <= kcte_pkg::CH_NINE);
  assign is_hex = (c >= kcte_pkg::CH_A) && (c <= kcte_pkg::CH_F);
  assign eff_ph = (phase_r == kcte_pkg::PH_PRE) ? kcte_pkg::PH_IDLE : phase_r;

  always_comb begin
    logic [BW-1:0] k;
    k         = '0;
    phase_nxt = phase_r;
    for (int i = 0; i < NK; i++) begin
      mpos_nxt[i] = mpos_r[i];
    end
    ncnt_nxt  = ncnt_r;
    mod_nxt   = mod_r;
    def_nxt   = def_r;
    ctrl_c    = '0;
    has_res   = 1'b0;
    res_n     = 2'd1;
    res_char  = kcte_pkg::CH_NUL;
    res_valid = 1'b0;
    res_end   = 1'b0;
    res_from  = 1'b0;
    case (q_head.kind)
      kcte_pkg::OP_CLEAR: begin
        phase_nxt = kcte_pkg::PH_PRE;
        for (int i = 0; i < NK; i++) begin
          mpos_nxt[i] = '0;
        end
        ncnt_nxt     = '0;
        mod_nxt      = '0;
        def_nxt      = '0;
        ctrl_c.clear = 1'b1;
      end
      kcte_pkg::OP_BEGIN: begin
        phase_nxt = kcte_pkg::PH_IDLE;
        has_res   = 1'b1;
        res_n     = 2'd2;
        res_char  = kcte_pkg::CH_SEMI;
        res_valid = 1'b1;
      end
      kcte_pkg::OP_DATA: begin
        phase_nxt = eff_ph;
        case (eff_ph)
          kcte_pkg::PH_IDLE: begin
            // all four matchers step; the later key wins on a common hit
            for (int i = 0; i < NK; i++) begin
              k = kcte_pkg::key_char(2'(i), mpos_r[i]);
              if (k == kcte_pkg::CH_NUL) begin
                mpos_nxt[i] = '0;
                phase_nxt   = kcte_pkg::key_phase(2'(i));
              end else if (c != k) begin
                mpos_nxt[i] = '0;
              end else begin
                mpos_nxt[i] = mpos_r[i] + 1'b1;
              end
            end
          end
          kcte_pkg::PH_NAME: begin
            if ((ncnt_r > NCW'(NAME_CHARS)) || eol) begin
              ctrl_c.close = 1'b1;
              phase_nxt    = kcte_pkg::PH_IDLE;
            end else begin
              ctrl_c.wr_en = 1'b1;
              ncnt_nxt     = ncnt_r + 1'b1;
            end
          end
          kcte_pkg::PH_MOD: begin
            if (is_dig) begin
              mod_nxt = (mod_r << 3) + (mod_r << 1) + {28'd0, c[3:0]};
            end
            if (eol) begin
              phase_nxt = kcte_pkg::PH_IDLE;
            end
          end
          kcte_pkg::PH_DEF: begin
            if (is_dig) begin
              def_nxt = {def_r[AW-5:0], c[3:0]};
            end else if (is_hex) begin
              def_nxt = {def_r[AW-5:0], c[3:0] + 4'd9};
            end
            if (eol) begin
              phase_nxt = kcte_pkg::PH_IDLE;
            end
          end
          kcte_pkg::PH_CONF: begin
            if (c == kcte_pkg::CH_QUOTE) begin
              has_res   = 1'b1;
              res_char  = kcte_pkg::CH_SEMI;
              res_valid = 1'b1;
            end else if (eol) begin
              phase_nxt = kcte_pkg::PH_IDLE;
            end else if (c != kcte_pkg::CH_NUL) begin
              has_res   = 1'b1;
              res_char  = c;
              res_valid = 1'b1;
            end
          end
          default: begin
            phase_nxt = kcte_pkg::PH_IDLE;
          end
        endcase
      end
      kcte_pkg::OP_EOF: begin
        has_res = 1'b1;
        res_end = 1'b1;
      end
      kcte_pkg::OP_READ: begin
        has_res      = 1'b1;
        res_valid    = q_head.idx_ok;
        res_from     = q_head.idx_ok;
        ctrl_c.rd_en = q_head.idx_ok;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  assign out_xfer = out_ch.valid && out_ch.ready;
  assign r_free   = (ocnt_r == 2'd0) || ((ocnt_r == 2'd1) && out_ch.ready);
  // items without a result need no room in the result register
  assign fire     = q_valid && (!has_res || r_free);
  assign q_pop    = fire;

  assign ns_ctrl    = fire ? ctrl_c : '0;
  assign ns_wr_byte = c;
  assign ns_count   = ncnt_r;
  assign ns_idx     = q_head.idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= kcte_pkg::PH_PRE;
      for (int i = 0; i < NK; i++) begin
        mpos_r[i] <= '0;
      end
      ncnt_r  <= '0;
      mod_r   <= '0;
      def_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      for (int i = 0; i < NK; i++) begin
        mpos_r[i] <= mpos_nxt[i];
      end
      ncnt_r  <= ncnt_nxt;
      mod_r   <= mod_nxt;
      def_r   <= def_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
    end else if (fire && has_res) begin
      ocnt_r <= res_n;
    end else if (out_xfer) begin
      ocnt_r <= ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_res) begin
      ochar_r  <= res_char;
      ovalid_r <= res_valid;
      oend_r   <= res_end;
      ofrom_r  <= res_from;
      omod_r   <= mod_nxt;
      odef_r   <= def_nxt;
    end
  end

  assign out_ch.valid         = (ocnt_r != 2'd0);
  assign out_ch.last          = (ocnt_r == 2'd1);
  assign out_ch.char_out      = ofrom_r ? ns_rd_char : ochar_r;
  assign out_ch.char_valid    = ovalid_r;
  assign out_ch.at_end        = oend_r;
  assign out_ch.mod_value     = omod_r;
  assign out_ch.default_value = odef_r;

endmodule

`default_nettype wire

>>> rtl/core/keyed_config_text_extractor_top.sv
// Path: an input transfer is written into the queue, then executed into the result register.
// Throughput: one input item per cycle while the queue has room; a begin command yields two
// results, both held in the single result register feeding the output channel.
// Reset: synchronous, active low; clears the queue, parser state, accumulators and
// name store flags at once (no clearing pass). Depends on kcte_pkg, kcte_if and
// kcte_front, kcte_name_store, kcte_back.
`timescale 1ns / 1ps
`default_nettype none

module keyed_config_text_extractor_top #(
  parameter int NAME_CHARS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  kcte_in_if.sink     in_ch,
  kcte_out_if.source  out_ch
);

  kcte_pkg::q_item_t                   q_head;
  logic                                q_valid;
  logic                                q_pop;
  kcte_pkg::ns_ctrl_t                  ns_ctrl;
  logic [kcte_pkg::BYTE_W-1:0]         ns_wr_byte;
  logic [$clog2(NAME_CHARS+2)-1:0]     ns_count;
  logic [kcte_pkg::IDX_W-1:0]          ns_idx;
  logic [kcte_pkg::BYTE_W-1:0]         ns_rd_char;

  kcte_front #(.NAME_CHARS(NAME_CHARS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  kcte_name_store #(.NAME_CHARS(NAME_CHARS)) u_name_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ns_ctrl),
    .wr_byte (ns_wr_byte),
    .count   (ns_count),
    .idx     (ns_idx),
    .rd_char (ns_rd_char)
  );

  kcte_back #(.NAME_CHARS(NAME_CHARS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .ns_ctrl    (ns_ctrl),
    .ns_wr_byte (ns_wr_byte),
    .ns_count   (ns_count),
    .ns_idx     (ns_idx),
    .ns_rd_char (ns_rd_char),
    .out_ch     (out_ch)
  );

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_begin_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=>
      (out_ch.valid && out_ch.last && out_ch.char_out == kcte_pkg::CH_SEMI))
    else $error("first begin result not followed by its closing result");

  a_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.command <= kcte_pkg::CMD_READ) |=> q_valid)
    else $error("accepted command did not reach the queue");

  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.at_end) |-> (!out_ch.char_valid && out_ch.last))
    else $error("end-of-file result malformed");

  a_q_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire
